### rtl/irc_line_tokenizer_top_macros.svh
// Assertion macros for the IRC line tokenizer.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef IRC_LINE_TOKENIZER_TOP_MACROS_SVH
`define IRC_LINE_TOKENIZER_TOP_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define IRC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next one.
`define IRC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

### rtl/ilt_pkg.sv
// Shared types and constants of the IRC line tokenizer.
// No dependencies; used by the keyword matcher and the top level.
package ilt_pkg;

  localparam int KW_COUNT   = 12;
  localparam int KW_MAX_LEN = 7;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] MAX_MIDDLE_RESET = 4'd14;
  localparam logic [3:0] CMD_LEN_MAX      = 4'd15;
  localparam logic [3:0] CMD_UNKNOWN      = 4'd0;
  localparam logic [3:0] CMD_NUMERIC      = 4'd13;

  // Keywords left-aligned and space padded; character i sits at [KW_MAX_LEN-1-i].
  localparam logic [KW_MAX_LEN-1:0][7:0] KW_TEXT [KW_COUNT] = '{
    "PASS   ", "NICK   ", "USER   ", "OPER   ", "MODE   ", "SERVICE",
    "QUIT   ", "SQUIT  ", "JOIN   ", "PART   ", "NOTICE ", "PRIVMSG"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd4, 4'd5, 4'd4, 4'd4, 4'd6, 4'd7
  };

  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_PREFIX = 7'b0000010,
    PH_CMD    = 7'b0000100,
    PH_PSTART = 7'b0001000,
    PH_MIDDLE = 7'b0010000,
    PH_TRAIL  = 7'b0100000,
    PH_CR     = 7'b1000000
  } ilt_phase_t;

  typedef enum logic [2:0] {
    FK_PREFIX   = 3'd0,
    FK_COMMAND  = 3'd1,
    FK_MIDDLE   = 3'd2,
    FK_TRAILING = 3'd3,
    FK_SPACE    = 3'd4,
    FK_CR       = 3'd5,
    FK_LF       = 3'd6
  } ilt_kind_t;

  typedef enum logic [1:0] {
    FE_OK       = 2'd0,
    FE_CR_EARLY = 2'd1,
    FE_LF_BARE  = 2'd2,
    FE_AFTER_CR = 2'd3
  } ilt_ferr_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    ilt_kind_t   field_kind;
    logic [3:0]  param_index;
    logic        line_done;
    logic [3:0]  command_code;
    logic [15:0] numeric_value;
    logic [3:0]  middle_count;
    logic        has_trailing;
    ilt_ferr_t   frame_error;
  } ilt_result_t;

endpackage

### rtl/ilt_byte_if.sv
// Input channel of the IRC line tokenizer: one raw line byte per word.
// No dependencies.
interface ilt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink (input valid, input line_byte, output ready);
endinterface

### rtl/ilt_token_if.sv
// Result channel of the IRC line tokenizer: one tagged byte plus line summary per word.
// No dependencies.
interface ilt_token_if;
  logic        valid;
  logic        ready;
  logic [7:0]  echo_byte;
  logic [2:0]  field_kind;
  logic [3:0]  param_index;
  logic        line_done;
  logic [3:0]  command_code;
  logic [15:0] numeric_value;
  logic [3:0]  middle_count;
  logic        has_trailing;
  logic [1:0]  frame_error;

  modport source (
    output valid, output echo_byte, output field_kind, output param_index,
    output line_done, output command_code, output numeric_value,
    output middle_count, output has_trailing, output frame_error, input ready
  );
  modport sink (
    input valid, input echo_byte, input field_kind, input param_index,
    input line_done, input command_code, input numeric_value,
    input middle_count, input has_trailing, input frame_error, output ready
  );
endinterface

### rtl/ilt_cmd_match.sv
// Command classifier: parallel compare of the stored command word against the keyword table.
// Depends on ilt_pkg.
module ilt_cmd_match import ilt_pkg::*; (
  input  logic [KW_MAX_LEN-1:0][7:0] cmd_chars,   // character i at [KW_MAX_LEN-1-i]
  input  logic [3:0]                 cmd_len,
  input  logic                       all_digits,
  output logic [3:0]                 cmd_code
);

  always_comb begin
    logic same;
    cmd_code = CMD_UNKNOWN;
    // Walk backwards so the lowest matching keyword wins.
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      same = (cmd_len == KW_LEN[k]);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (4'(i) < KW_LEN[k] &&
            cmd_chars[KW_MAX_LEN-1-i] != KW_TEXT[k][KW_MAX_LEN-1-i]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        cmd_code = 4'(k + 1);
      end
    end
    if (cmd_len == 4'd0) begin
      cmd_code = CMD_UNKNOWN;
    end else if (all_digits) begin
      cmd_code = CMD_NUMERIC;
    end
  end

endmodule

### rtl/irc_line_tokenizer_top.sv
// IRC line tokenizer: tags each byte of a message line and summarizes the line on LF.
// A result is registered and valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register accepts a new byte when it is
// empty or being drained in the same cycle, so only a stalled output stops input.
// Reset (rst_n low, synchronous): line state to start of line, limit to 14, output empty.
module irc_line_tokenizer_top import ilt_pkg::*; #(
  parameter int COMMAND_CHARS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  ilt_byte_if.sink   in_ch,
  ilt_token_if.source out_ch
);

`include "irc_line_tokenizer_top_macros.svh"

  localparam int CIW = $clog2(COMMAND_CHARS);

  logic [3:0]  max_mid_r;
  ilt_phase_t  phase_r, phase_nxt;
  logic [7:0]  cmd_chars_r [COMMAND_CHARS];
  logic [3:0]  cmd_len_r, cmd_len_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        all_dig_r, all_dig_nxt;
  logic [3:0]  mid_seen_r, mid_seen_nxt;
  logic        trail_r, trail_nxt;
  ilt_ferr_t   err_r, err_nxt;
  ilt_result_t res_r, res_nxt;
  logic        out_valid_r;

  logic        in_fire;
  logic        take_cmd;
  logic [7:0]  b;
  logic        is_digit;
  logic [19:0] acc_wide;
  logic [3:0]  cmd_code;
  logic [KW_MAX_LEN-1:0][7:0] cmd_word;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.line_byte;

  always_comb begin
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      cmd_word[KW_MAX_LEN-1-i] = cmd_chars_r[i];
    end
  end

  ilt_cmd_match u_match (
    .cmd_chars  (cmd_word),
    .cmd_len    (cmd_len_r),
    .all_digits (all_dig_r),
    .cmd_code   (cmd_code)
  );

  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign acc_wide = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {12'b0, b - CHAR_ZERO};

  always_comb begin
    phase_nxt    = phase_r;
    cmd_len_nxt  = cmd_len_r;
    acc_nxt      = acc_r;
    all_dig_nxt  = all_dig_r;
    mid_seen_nxt = mid_seen_r;
    trail_nxt    = trail_r;
    err_nxt      = err_r;
    take_cmd     = 1'b0;
    res_nxt      = '0;
    res_nxt.echo_byte  = b;
    res_nxt.field_kind = FK_TRAILING;

    if (b == CHAR_LF) begin
      res_nxt.field_kind    = FK_LF;
      res_nxt.line_done     = 1'b1;
      res_nxt.command_code  = cmd_code;
      res_nxt.numeric_value = (cmd_code == CMD_NUMERIC) ? acc_r : 16'd0;
      res_nxt.middle_count  = mid_seen_r;
      res_nxt.has_trailing  = trail_r;
      res_nxt.frame_error   = (err_r == FE_OK && phase_r != PH_CR) ? FE_LF_BARE : err_r;
      // Drop the line state for the next message.
      phase_nxt    = PH_START;
      cmd_len_nxt  = '0;
      acc_nxt      = '0;
      all_dig_nxt  = 1'b1;
      mid_seen_nxt = '0;
      trail_nxt    = 1'b0;
      err_nxt      = FE_OK;
    end else if (phase_r == PH_CR) begin
      res_nxt.field_kind = FK_CR;
      if (err_r == FE_OK) begin
        err_nxt = FE_AFTER_CR;
      end
    end else if (b == CHAR_CR) begin
      res_nxt.field_kind = FK_CR;
      phase_nxt          = PH_CR;
      if (err_r == FE_OK &&
          (phase_r == PH_START || phase_r == PH_PREFIX || phase_r == PH_CMD)) begin
        err_nxt = FE_CR_EARLY;
      end
    end else begin
      unique case (phase_r)
        PH_START: begin
          if (b == CHAR_COLON) begin
            res_nxt.field_kind = FK_PREFIX;
            phase_nxt          = PH_PREFIX;
          end else if (b == CHAR_SPACE) begin
            res_nxt.field_kind = FK_SPACE;
            phase_nxt          = PH_PSTART;
          end else begin
            res_nxt.field_kind = FK_COMMAND;
            take_cmd           = 1'b1;
            phase_nxt          = PH_CMD;
          end
        end
        PH_PREFIX: begin
          if (b == CHAR_SPACE) begin
            res_nxt.field_kind = FK_SPACE;
            phase_nxt          = PH_CMD;
          end else begin
            res_nxt.field_kind = FK_PREFIX;
          end
        end
        PH_CMD: begin
          if (b == CHAR_SPACE) begin
            res_nxt.field_kind = FK_SPACE;
            phase_nxt          = PH_PSTART;
          end else begin
            res_nxt.field_kind = FK_COMMAND;
            take_cmd           = 1'b1;
          end
        end
        PH_PSTART: begin
          if (b == CHAR_SPACE) begin
            res_nxt.field_kind = FK_SPACE;
          end else if (b == CHAR_COLON || mid_seen_r >= max_mid_r) begin
            res_nxt.field_kind = FK_TRAILING;
            trail_nxt          = 1'b1;
            phase_nxt          = PH_TRAIL;
          end else begin
            res_nxt.field_kind  = FK_MIDDLE;
            res_nxt.param_index = mid_seen_r;
            mid_seen_nxt        = mid_seen_r + 4'd1;
            phase_nxt           = PH_MIDDLE;
          end
        end
        PH_MIDDLE: begin
          if (b == CHAR_SPACE) begin
            res_nxt.field_kind = FK_SPACE;
            phase_nxt          = PH_PSTART;
          end else begin
            res_nxt.field_kind  = FK_MIDDLE;
            res_nxt.param_index = mid_seen_r - 4'd1;
          end
        end
        PH_TRAIL, PH_CR: begin
          res_nxt.field_kind = FK_TRAILING;
        end
        default: begin
          res_nxt.field_kind = FK_TRAILING;
        end
      endcase
    end

    if (take_cmd) begin
      if (cmd_len_r != CMD_LEN_MAX) begin
        cmd_len_nxt = cmd_len_r + 4'd1;
      end
      if (is_digit) begin
        acc_nxt = (|acc_wide[19:16]) ? 16'hFFFF : acc_wide[15:0];
      end else begin
        all_dig_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mid_r   <= MAX_MIDDLE_RESET;
      phase_r     <= PH_START;
      cmd_len_r   <= '0;
      acc_r       <= '0;
      all_dig_r   <= 1'b1;
      mid_seen_r  <= '0;
      trail_r     <= 1'b0;
      err_r       <= FE_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_mid_r <= cfg_data;
      end
      if (in_fire) begin
        phase_r    <= phase_nxt;
        cmd_len_r  <= cmd_len_nxt;
        acc_r      <= acc_nxt;
        all_dig_r  <= all_dig_nxt;
        mid_seen_r <= mid_seen_nxt;
        trail_r    <= trail_nxt;
        err_r      <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command bytes beyond the stored length are never compared, so no clear is needed.
  always_ff @(posedge clk) begin
    if (in_fire && take_cmd && ({1'b0, cmd_len_r} < 5'(COMMAND_CHARS))) begin
      cmd_chars_r[cmd_len_r[CIW-1:0]] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.echo_byte     = res_r.echo_byte;
  assign out_ch.field_kind    = res_r.field_kind;
  assign out_ch.param_index   = res_r.param_index;
  assign out_ch.line_done     = res_r.line_done;
  assign out_ch.command_code  = res_r.command_code;
  assign out_ch.numeric_value = res_r.numeric_value;
  assign out_ch.middle_count  = res_r.middle_count;
  assign out_ch.has_trailing  = res_r.has_trailing;
  assign out_ch.frame_error   = res_r.frame_error;

  `IRC_ASSERT_NEXT(a_lf_clears_line, in_fire && (b == CHAR_LF), phase_r == PH_START && mid_seen_r == 4'd0 && err_r == FE_OK, "LF did not clear the line state")
  `IRC_ASSERT_ALWAYS(a_done_is_lf, !(out_valid_r && res_r.line_done) || res_r.field_kind == FK_LF, "line_done on a byte that is not LF")
  `IRC_ASSERT_ALWAYS(a_summary_only_on_done, res_r.line_done || !out_valid_r || (res_r.frame_error == FE_OK && res_r.middle_count == 4'd0 && res_r.command_code == CMD_UNKNOWN), "summary fields set without line_done")
  `IRC_ASSERT_ALWAYS(a_numeric_code, !out_valid_r || res_r.numeric_value == 16'd0 || res_r.command_code == CMD_NUMERIC, "numeric value without numeric command")
  `IRC_ASSERT_NEXT(a_cr_holds, in_fire && (phase_r == PH_CR) && (b != CHAR_LF), phase_r == PH_CR && err_r != FE_OK, "left CR wait without LF")

endmodule
